/* hdl/sitoa_pkg.sv */
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitoa_pkg;

	localparam int MAG_W         = 32;
	localparam int NUM_DIGITS    = 10;
	localparam int DIGIT_W       = 4;
	localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
	localparam int STEP_W        = 3;
	localparam int LEN_W         = 4;
	localparam int CHAR_W        = 8;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	// one classified number waiting for the emitter
	typedef struct packed {
		logic             neg;
		bcd_t             bcd;
		logic [LEN_W-1:0] len;
	} q_entry_t;

endpackage

/* hdl/sitoa_if.sv */
// ----------------------------------------------------------------------------
// sitoa_if
// Valid/ready channels for numbers in and characters out.
// ----------------------------------------------------------------------------
interface sitoa_num_if import sitoa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sitoa_char_if import sitoa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              is_last;
	logic [LEN_W-1:0]  text_length;

	modport source (output valid, output character, output is_last, output text_length,
		input ready);
	modport sink (input valid, input character, input is_last, input text_length,
		output ready);
endinterface

/* hdl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output request, most significant first.
// ----------------------------------------------------------------------------
// usage:
//   number : valid/ready sink, one request per 32-bit two's complement value
//   text   : valid/ready source, one request per character ('-' or a digit),
//            is_last marks the final character, text_length (1..11) is the
//            total count of the number and repeats on each of its characters
// flow:
//   the converter accepts a number, runs 8 shift-and-add-3 steps of 4 bits
//   each and hands the result to the queue, taking no new number until the
//   hand-off is done; the emitter loads a queued entry, then emits its
//   characters in order and loads the next entry after the last one
// reset: arst_n clears the converter, queue and emitter; no output pending
// stall: a stalled receiver holds the output register; the emitter waits,
//   the two-entry queue fills, then the converter waits and number.ready
//   stays low until space frees up
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sitoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sitoa_num_if.sink     number,
	sitoa_char_if.source  text
);

	// front to queue
	logic     q_push_valid;
	logic     q_push_ready;
	q_entry_t q_push_data;

	// queue to back
	logic     q_pop_valid;
	logic     q_pop;
	q_entry_t q_pop_data;

	// sign split and binary to BCD conversion
	sitoa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.number     (number),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	// decouples conversion from character emission
	sitoa_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop        (q_pop),
		.pop_data   (q_pop_data)
	);

	// character sequencer with registered output
	sitoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_data  (q_pop_data),
		.pop       (q_pop),
		.text      (text)
	);

`ifndef SYNTH
	// converter is busy after taking a number and does not accept back-to-back numbers
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		number.valid && number.ready |=> !number.ready)
		else $error("converter accepted back-to-back numbers");

	// emitter only pops a queue that holds an entry
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_pop_valid)
		else $error("pop from empty queue");

	// a minus sign is always followed by digits
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && (text.character == CHAR_MINUS) |-> !text.is_last)
		else $error("minus sign marked as last character");
`endif

endmodule

/* hdl/sitoa_fifo.sv */
// ----------------------------------------------------------------------------
// sitoa_fifo
// Short queue of classified numbers between converter and emitter.
// ----------------------------------------------------------------------------
module sitoa_fifo import sitoa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop,
	output q_entry_t pop_data
);

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/sitoa_front.sv */
// ----------------------------------------------------------------------------
// sitoa_front
// Takes a number, splits off the sign and converts the magnitude to BCD.
// ----------------------------------------------------------------------------
module sitoa_front import sitoa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sitoa_num_if.sink number,
	output logic      push_valid,
	input  logic      push_ready,
	output q_entry_t  push_data
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t       state_q;
	logic [STEP_W-1:0]  step_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_next;
	logic [MAG_W-1:0]   raw;
	logic [LEN_W-1:0]   ndig;
	logic               accept;

	assign number.ready = (state_q == F_IDLE);
	assign accept       = number.valid && number.ready;
	assign raw          = number.value;

	// shift-and-add-3, four magnitude bits per cycle
	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd_next[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			bcd_next = {bcd_next[BCD_W-2:0], mag_q[MAG_W-1-b]};
		end
	end

	// digit count: highest nonzero digit, at least one
	always_comb begin
		ndig = LEN_W'(1);
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
				ndig = LEN_W'(d + 1);
			end
		end
	end

	assign push_valid    = (state_q == F_PUSH);
	assign push_data.neg = neg_q;
	assign push_data.bcd = bcd_q;
	assign push_data.len = ndig + LEN_W'(neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						step_q  <= '0;
					end
				end
				F_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CONV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[MAG_W-1];
			mag_q <= raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
			bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			bcd_q <= bcd_next;
			mag_q <= mag_q << BITS_PER_STEP;
		end
	end

endmodule

/* hdl/sitoa_back.sv */
// ----------------------------------------------------------------------------
// sitoa_back
// Emits the characters of one queued number, sign first, into an output register.
// ----------------------------------------------------------------------------
module sitoa_back import sitoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  q_entry_t      pop_data,
	output logic          pop,
	sitoa_char_if.source  text
);

	logic              busy_q;
	logic              sign_q;
	bcd_t              bcd_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  didx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [LEN_W-1:0]  tlen_q;
	logic              advance;
	logic              done;

	assign pop     = !busy_q && pop_valid;
	assign advance = busy_q && (!out_valid_q || text.ready);
	assign done    = advance && !sign_q && (didx_q == '0);

	assign text.valid       = out_valid_q;
	assign text.character   = char_q;
	assign text.is_last     = last_q;
	assign text.text_length = tlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sign_q <= pop_data.neg;
			bcd_q  <= pop_data.bcd;
			len_q  <= pop_data.len;
			didx_q <= pop_data.len - LEN_W'(pop_data.neg) - LEN_W'(1);
		end else if (advance) begin
			tlen_q <= len_q;
			if (sign_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
				sign_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + CHAR_W'(bcd_q[didx_q]);
				last_q <= (didx_q == '0);
				didx_q <= didx_q - 1'b1;
			end
		end
	end

endmodule
